// File: hdl/fat_chain_table_macros.svh
// Assertion macros used by the chain table controller.
`ifndef FAT_CHAIN_TABLE_MACROS_SVH
`define FAT_CHAIN_TABLE_MACROS_SVH

// Condition and consequence in the same cycle.
`define FCT_ASSERT_SAME(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |-> (post)) \
        else $error("fct: same-cycle check failed");

// Consequence in the cycle after the condition.
`define FCT_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (pre) |=> (post)) \
        else $error("fct: next-cycle check failed");

`endif

// File: hdl/fct_pkg.sv
// Types and constants of the file allocation table chain manager.
`timescale 1ns / 1ps

package fct_pkg;

    localparam int BLK_W   = 7;
    localparam int ENTRY_W = 8;

    localparam logic [2:0] ACT_WRITE  = 3'd0;
    localparam logic [2:0] ACT_READ   = 3'd1;
    localparam logic [2:0] ACT_ALLOC  = 3'd2;
    localparam logic [2:0] ACT_FOLLOW = 3'd3;
    localparam logic [2:0] ACT_FREE   = 3'd4;

    localparam logic [ENTRY_W-1:0] ENTRY_FREE = 8'h00;
    localparam logic [ENTRY_W-1:0] ENTRY_END  = 8'hFF;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_START,
        ST_READ,
        ST_SCAN,
        ST_ALLOC_END,
        ST_FOLLOW,
        ST_FREE,
        ST_DONE
    } st_t;

    typedef struct packed {
        logic we;
        logic re;
    } mem_cmd_t;

    typedef struct packed {
        logic               load;
        logic [ENTRY_W-1:0] result_block;
        logic [ENTRY_W-1:0] read_value;
        logic               success;
    } res_t;

endpackage

// File: hdl/fat_chain_table.sv
// Top level of the file allocation table chain manager.
// Allocate scans from entry 0 for the first free entry; follow walks up to step_count links;
// free walks the chain from start_block and clears at most NUM_BLOCKS entries.
// The table's single read port walks one entry per cycle; one item is in work at a time.
// Reset clears per-entry valid bits at once, so the table reads all free with no sweep.
`timescale 1ns / 1ps

module fat_chain_table
    import fct_pkg::*;
#(
    parameter int NUM_BLOCKS = 128
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    // start_block[6:0], step_count[13:7], link_previous[14], previous_block[21:15],
    // entry_value[29:22], zero fill[31:30]
    input  logic [31:0] s_tdata,
    // action[2:0]
    input  logic [2:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // result_block[7:0], read_value[15:8]
    output logic [15:0] m_tdata,
    // success
    output logic        m_tuser
);

    localparam int AW = $clog2(NUM_BLOCKS);

    mem_cmd_t           mem_cmd;
    logic [AW-1:0]      mem_waddr;
    logic [AW-1:0]      mem_raddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;
    res_t               res;
    logic               out_free;

    logic               m_valid_reg;
    logic [15:0]        m_data_reg;
    logic               m_user_reg;

    assign out_free = !m_valid_reg || m_tready;

    fct_ctrl #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .AW        (AW)
    ) u_ctrl (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .in_valid         (s_tvalid),
        .in_ready         (s_tready),
        .in_action        (s_tuser),
        .in_start_block   (s_tdata[6:0]),
        .in_step_count    (s_tdata[13:7]),
        .in_link_previous (s_tdata[14]),
        .in_previous_block(s_tdata[21:15]),
        .in_entry_value   (s_tdata[29:22]),
        .out_free         (out_free),
        .res              (res),
        .mem_cmd          (mem_cmd),
        .mem_waddr        (mem_waddr),
        .mem_wdata        (mem_wdata),
        .mem_raddr        (mem_raddr),
        .mem_rdata        (mem_rdata)
    );

    fct_mem #(
        .NUM_BLOCKS(NUM_BLOCKS),
        .AW        (AW)
    ) u_mem (
        .aclk   (aclk),
        .aresetn(aresetn),
        .cmd    (mem_cmd),
        .waddr  (mem_waddr),
        .wdata  (mem_wdata),
        .raddr  (mem_raddr),
        .rdata  (mem_rdata)
    );

    // Output register: a finished item waits here while the next one is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (res.load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (res.load) begin
            m_data_reg <= {res.read_value, res.result_block};
            m_user_reg <= res.success;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;

endmodule

// File: hdl/fct_mem.sv
// Table storage: one write and one registered read per cycle, per-entry valid bits.
`timescale 1ns / 1ps

module fct_mem
    import fct_pkg::*;
#(
    parameter int NUM_BLOCKS = 128,
    parameter int AW         = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  mem_cmd_t           cmd,
    input  logic [AW-1:0]      waddr,
    input  logic [ENTRY_W-1:0] wdata,
    input  logic [AW-1:0]      raddr,
    output logic [ENTRY_W-1:0] rdata
);

    logic [ENTRY_W-1:0]    table_mem [NUM_BLOCKS];
    logic [NUM_BLOCKS-1:0] valid_reg;
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  rd_vld_reg;

    // Entries never written since reset read as free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (cmd.we) begin
            valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.we) begin
            table_mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.re) begin
            rd_data_reg <= table_mem[raddr];
            rd_vld_reg  <= valid_reg[raddr];
        end
    end

    assign rdata = rd_vld_reg ? rd_data_reg : ENTRY_FREE;

endmodule

// File: hdl/fct_ctrl.sv
// Sequencer that walks the table one entry per cycle for the allocate, follow and free actions.
`timescale 1ns / 1ps
`include "fat_chain_table_macros.svh"

module fct_ctrl
    import fct_pkg::*;
#(
    parameter int NUM_BLOCKS = 128,
    parameter int AW         = 7
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_action,
    input  logic [BLK_W-1:0]   in_start_block,
    input  logic [BLK_W-1:0]   in_step_count,
    input  logic               in_link_previous,
    input  logic [BLK_W-1:0]   in_previous_block,
    input  logic [ENTRY_W-1:0] in_entry_value,
    input  logic               out_free,
    output res_t               res,
    output mem_cmd_t           mem_cmd,
    output logic [AW-1:0]      mem_waddr,
    output logic [ENTRY_W-1:0] mem_wdata,
    output logic [AW-1:0]      mem_raddr,
    input  logic [ENTRY_W-1:0] mem_rdata
);

    localparam logic [ENTRY_W-1:0] NB8       = ENTRY_W'(NUM_BLOCKS);
    localparam logic [AW-1:0]      LAST_BLK  = AW'(NUM_BLOCKS - 1);

    st_t                st_reg, st_next;
    logic [2:0]         act_reg, act_next;
    logic [BLK_W-1:0]   start_reg, start_next;
    logic [BLK_W-1:0]   steps_reg, steps_next;
    logic               link_reg, link_next;
    logic [BLK_W-1:0]   prev_reg, prev_next;
    logic [ENTRY_W-1:0] value_reg, value_next;
    logic [AW-1:0]      scan_reg, scan_next;
    logic [AW-1:0]      cur_reg, cur_next;
    logic [7:0]         cnt_reg, cnt_next;
    logic [ENTRY_W-1:0] result_reg, result_next;
    logic [ENTRY_W-1:0] readv_reg, readv_next;
    logic               ok_reg, ok_next;

    logic start_ok;
    logic prev_ok;
    logic rd_is_link;
    logic rd_free;
    logic last_step;
    logic free_more;

    assign start_ok   = {1'b0, start_reg} < NB8;
    assign prev_ok    = {1'b0, prev_reg} < NB8;
    assign rd_is_link = (mem_rdata != ENTRY_FREE) && !mem_rdata[ENTRY_W-1] && (mem_rdata < NB8);
    assign rd_free    = mem_rdata == ENTRY_FREE;
    assign last_step  = cnt_reg == 8'd1;
    // A block that links to itself is cleared in this very cycle, so the walk ends there.
    assign free_more  = rd_is_link && !last_step && (mem_rdata[AW-1:0] != cur_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= ST_IDLE;
        end else begin
            st_reg <= st_next;
        end
    end

    always_ff @(posedge aclk) begin
        act_reg    <= act_next;
        start_reg  <= start_next;
        steps_reg  <= steps_next;
        link_reg   <= link_next;
        prev_reg   <= prev_next;
        value_reg  <= value_next;
        scan_reg   <= scan_next;
        cur_reg    <= cur_next;
        cnt_reg    <= cnt_next;
        result_reg <= result_next;
        readv_reg  <= readv_next;
        ok_reg     <= ok_next;
    end

    // Next state.
    always_comb begin
        st_next = st_reg;
        case (st_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    st_next = ST_START;
                end
            end
            ST_START: begin
                case (act_reg)
                    ACT_READ: begin
                        st_next = start_ok ? ST_READ : ST_DONE;
                    end
                    ACT_ALLOC: begin
                        st_next = ST_SCAN;
                    end
                    ACT_FOLLOW: begin
                        st_next = (start_ok && steps_reg != '0) ? ST_FOLLOW : ST_DONE;
                    end
                    ACT_FREE: begin
                        st_next = start_ok ? ST_FREE : ST_DONE;
                    end
                    default: begin
                        st_next = ST_DONE;
                    end
                endcase
            end
            ST_READ: begin
                st_next = ST_DONE;
            end
            ST_SCAN: begin
                if (rd_free) begin
                    st_next = ST_ALLOC_END;
                end else if (scan_reg == LAST_BLK) begin
                    st_next = ST_DONE;
                end
            end
            ST_ALLOC_END: begin
                st_next = ST_DONE;
            end
            ST_FOLLOW: begin
                if (!rd_is_link || last_step) begin
                    st_next = ST_DONE;
                end
            end
            ST_FREE: begin
                if (!free_more) begin
                    st_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    st_next = ST_IDLE;
                end
            end
            default: begin
                st_next = ST_IDLE;
            end
        endcase
    end

    // Outputs and datapath.
    always_comb begin
        in_ready    = 1'b0;
        mem_cmd     = '0;
        mem_waddr   = cur_reg;
        mem_wdata   = ENTRY_FREE;
        mem_raddr   = scan_reg;
        act_next    = act_reg;
        start_next  = start_reg;
        steps_next  = steps_reg;
        link_next   = link_reg;
        prev_next   = prev_reg;
        value_next  = value_reg;
        scan_next   = scan_reg;
        cur_next    = cur_reg;
        cnt_next    = cnt_reg;
        result_next = result_reg;
        readv_next  = readv_reg;
        ok_next     = ok_reg;
        res.load         = 1'b0;
        res.result_block = result_reg;
        res.read_value   = readv_reg;
        res.success      = ok_reg;
        case (st_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                if (in_valid) begin
                    act_next   = in_action;
                    start_next = in_start_block;
                    steps_next = in_step_count;
                    link_next  = in_link_previous;
                    prev_next  = in_previous_block;
                    value_next = in_entry_value;
                end
            end
            ST_START: begin
                result_next = ENTRY_FREE;
                readv_next  = ENTRY_FREE;
                ok_next     = 1'b1;
                case (act_reg)
                    ACT_WRITE: begin
                        if (start_ok) begin
                            mem_cmd.we = 1'b1;
                            mem_waddr  = start_reg[AW-1:0];
                            mem_wdata  = value_reg;
                        end
                    end
                    ACT_READ: begin
                        mem_cmd.re = start_ok;
                        mem_raddr  = start_reg[AW-1:0];
                    end
                    ACT_ALLOC: begin
                        scan_next  = '0;
                        mem_cmd.re = 1'b1;
                        mem_raddr  = '0;
                    end
                    ACT_FOLLOW: begin
                        result_next = {1'b0, start_reg};
                        cnt_next    = {1'b0, steps_reg};
                        mem_cmd.re  = start_ok && steps_reg != '0;
                        mem_raddr   = start_reg[AW-1:0];
                    end
                    ACT_FREE: begin
                        cnt_next   = 8'(NUM_BLOCKS);
                        cur_next   = start_reg[AW-1:0];
                        mem_cmd.re = start_ok;
                        mem_raddr  = start_reg[AW-1:0];
                    end
                    default: begin
                        result_next = ENTRY_FREE;
                    end
                endcase
            end
            ST_READ: begin
                readv_next = mem_rdata;
            end
            ST_SCAN: begin
                if (rd_free) begin
                    result_next = ENTRY_W'(scan_reg);
                    // The link goes in first so that a self link ends up as the end mark.
                    if (link_reg && prev_ok) begin
                        mem_cmd.we = 1'b1;
                        mem_waddr  = prev_reg[AW-1:0];
                        mem_wdata  = ENTRY_W'(scan_reg);
                    end
                end else if (scan_reg == LAST_BLK) begin
                    result_next = ENTRY_END;
                    ok_next     = 1'b0;
                end else begin
                    scan_next  = scan_reg + 1'b1;
                    mem_cmd.re = 1'b1;
                    mem_raddr  = scan_reg + 1'b1;
                end
            end
            ST_ALLOC_END: begin
                mem_cmd.we = 1'b1;
                mem_waddr  = scan_reg;
                mem_wdata  = ENTRY_END;
            end
            ST_FOLLOW: begin
                cnt_next = cnt_reg - 8'd1;
                if (!rd_is_link || last_step) begin
                    result_next = mem_rdata;
                end else begin
                    mem_cmd.re = 1'b1;
                    mem_raddr  = mem_rdata[AW-1:0];
                end
            end
            ST_FREE: begin
                // Clear the visited entry and fetch the next one in the same cycle.
                mem_cmd.we = 1'b1;
                mem_waddr  = cur_reg;
                mem_wdata  = ENTRY_FREE;
                cnt_next   = cnt_reg - 8'd1;
                if (free_more) begin
                    mem_cmd.re = 1'b1;
                    mem_raddr  = mem_rdata[AW-1:0];
                    cur_next   = mem_rdata[AW-1:0];
                end
            end
            ST_DONE: begin
                res.load = out_free;
            end
            default: begin
                res.load = 1'b0;
            end
        endcase
    end

    `FCT_ASSERT_SAME(a_end_after_scan, st_reg == ST_ALLOC_END, $past(st_reg) == ST_SCAN)
    `FCT_ASSERT_SAME(a_follow_cnt, st_reg == ST_FOLLOW, cnt_reg != 8'd0)
    `FCT_ASSERT_SAME(a_free_cnt, st_reg == ST_FREE, cnt_reg != 8'd0)
    `FCT_ASSERT_NEXT(a_done_idle, st_reg == ST_DONE && out_free, st_reg == ST_IDLE)

endmodule
